// File: src/scd_pkg.sv
package scd_pkg;

    localparam int DELAY_DEPTH  = 4096;
    localparam int ADDR_W       = $clog2(DELAY_DEPTH);
    localparam int CENTER_DELAY = 960;
    localparam int ROM_SIZE     = 256;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [20:0] CENTER_Q8    = 21'(CENTER_DELAY * 256);

    localparam logic [31:0] PHASE_STEP_RESET = 32'd89478;
    localparam logic [17:0] DEPTH_RESET      = 18'd36864;
    localparam logic [15:0] GAIN_RESET       = 16'd16384;

    localparam logic [7:0] CFG_PHASE_STEP = 8'd0;
    localparam logic [7:0] CFG_DEPTH      = 8'd1;
    localparam logic [7:0] CFG_DRY        = 8'd2;
    localparam logic [7:0] CFG_WET        = 8'd3;

    typedef struct packed {
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
        logic               block_start;
    } in_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } out_t;

    // one item as handed from the front to the back
    typedef struct packed {
        logic signed [15:0] x_l;
        logic signed [15:0] x_r;
        logic [ADDR_W-1:0]  whole_l;
        logic [ADDR_W-1:0]  whole_r;
        logic [7:0]         frac_l;
        logic [7:0]         frac_r;
        logic [15:0]        dry;
        logic [15:0]        wet;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        F_IDLE, F_LFO_L, F_LFO_R, F_OFF_L, F_OFF_R, F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR, B_IDLE, B_RD1, B_Y0, B_Y1, B_MUL, B_OUT
    } back_state_t;

    typedef logic signed [15:0] rom_t [ROM_SIZE];

    // shift and subtract long division, used only while building the ROM
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = (r << 1) | ((num >> i) & 64'd1);
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // round(32767*sin(k*pi/128)), Q30 series
    function automatic logic [15:0] quarter_sine(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        x    = (longint'(k) * 64'd3373259426 + 64'd64) >> 7;
        x2   = (x * x) >> 30;
        sum  = longint'(x);
        term = x;
        for (int n = 1; n <= 8; n++) begin
            term = udiv((term * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
            if (n % 2 == 1) sum = sum - longint'(term);
            else            sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > 64'sd1073741824) sum = 64'sd1073741824;
        v = (longint'(sum) * 64'd32767 + 64'd536870912) >> 30;
        if (v > 64'd32767) v = 64'd32767;
        return v[15:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        logic [15:0] s;
        for (int i = 0; i < ROM_SIZE; i++) begin
            s = ((i / 64) % 2 == 1) ? quarter_sine(64 - i % 64) : quarter_sine(i % 64);
            r[i] = ((i / 64) >= 2) ? -$signed(s) : $signed(s);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // now + (target - now) * 75 / 256, truncating toward zero
    function automatic logic [18:0] smooth(input logic [18:0] now, input logic [18:0] tgt);
        logic signed [19:0] diff;
        logic signed [26:0] prod;
        logic signed [26:0] q;
        diff = $signed({1'b0, tgt}) - $signed({1'b0, now});
        prod = 27'(diff) * 27'sd75;
        q    = (prod < 0) ? ((prod + 27'sd255) >>> 8) : (prod >>> 8);
        return now + q[18:0];
    endfunction

endpackage

// File: src/scd_fifo.sv
module scd_fifo import scd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  job_t    push_data,
    input  logic    pop,
    output job_t    pop_data,
    output q_stat_t stat
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: src/scd_front.sv
module scd_front import scd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    input  logic        cfg_valid,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        hold,
    input  q_stat_t     q_stat,
    output logic        push,
    output job_t        push_data
);

    front_state_t state_reg, state_next;

    logic [31:0] step_tgt_reg, step_now_reg, phase_reg;
    logic [17:0] depth_tgt_reg, depth_now_reg;
    logic [14:0] dry_tgt_reg, wet_tgt_reg;
    logic [15:0] dry_now_reg, wet_now_reg;
    logic signed [15:0] xl_reg, xr_reg, lfo_l_reg, lfo_r_reg;
    logic [18:0] off_l_reg, off_r_reg;

    logic [31:0]        ph;
    logic [7:0]         idx;
    logic signed [16:0] a, b, diff;
    logic signed [33:0] lprod;
    logic signed [17:0] lfo_sum;
    logic signed [15:0] lfo_sel;
    logic signed [34:0] oprod;
    logic signed [20:0] off_full;
    logic [18:0]        off_clamp;
    logic [18:0]        depth_sm, dry_sm, wet_sm;
    logic               accept;

    assign accept = s_valid && s_ready;

    // LFO interpolation, shared by both channels
    always_comb begin
        ph      = (state_reg == F_LFO_R) ? phase_reg + QUARTER_TURN : phase_reg;
        idx     = ph[31:24];
        a       = 17'(SINE_ROM[idx]);
        b       = 17'(SINE_ROM[8'(idx + 8'd1)]);
        diff    = b - a;
        lprod   = 34'(diff) * $signed({18'd0, ph[23:8]});
        lfo_sum = 18'(a) + 18'(lprod >>> 16);
    end

    // tap offset in Q8, shared by both channels
    always_comb begin
        lfo_sel   = (state_reg == F_OFF_R) ? lfo_r_reg : lfo_l_reg;
        oprod     = 35'(lfo_sel) * $signed({17'd0, depth_now_reg});
        off_full  = $signed(CENTER_Q8) + 21'(oprod >>> 15);
        off_clamp = off_full[20] ? 19'd0 : off_full[18:0];
    end

    always_comb begin
        depth_sm = smooth({1'b0, depth_now_reg}, {1'b0, depth_tgt_reg});
        dry_sm   = smooth({3'd0, dry_now_reg}, {4'd0, dry_tgt_reg});
        wet_sm   = smooth({3'd0, wet_now_reg}, {4'd0, wet_tgt_reg});
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        push       = 1'b0;
        case (state_reg)
            F_IDLE: begin
                s_ready = !hold;
                if (accept) state_next = F_LFO_L;
            end
            F_LFO_L: state_next = F_LFO_R;
            F_LFO_R: state_next = F_OFF_L;
            F_OFF_L: state_next = F_OFF_R;
            F_OFF_R: state_next = F_PUSH;
            F_PUSH: begin
                if (!q_stat.full) begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        push_data.x_l     = xl_reg;
        push_data.x_r     = xr_reg;
        push_data.whole_l = ADDR_W'(off_l_reg[18:8]);
        push_data.whole_r = ADDR_W'(off_r_reg[18:8]);
        push_data.frac_l  = off_l_reg[7:0];
        push_data.frac_r  = off_r_reg[7:0];
        push_data.dry     = dry_now_reg;
        push_data.wet     = wet_now_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= F_IDLE;
        else          state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_tgt_reg  <= PHASE_STEP_RESET;
            depth_tgt_reg <= DEPTH_RESET;
            dry_tgt_reg   <= GAIN_RESET[14:0];
            wet_tgt_reg   <= GAIN_RESET[14:0];
            step_now_reg  <= PHASE_STEP_RESET;
            depth_now_reg <= DEPTH_RESET;
            dry_now_reg   <= GAIN_RESET;
            wet_now_reg   <= GAIN_RESET;
            phase_reg     <= 32'd0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_PHASE_STEP: step_tgt_reg  <= cfg_data;
                    CFG_DEPTH:      depth_tgt_reg <= cfg_data[17:0];
                    CFG_DRY:        dry_tgt_reg   <= cfg_data[14:0];
                    CFG_WET:        wet_tgt_reg   <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (accept && s_data.block_start) begin
                step_now_reg  <= step_tgt_reg;
                depth_now_reg <= depth_sm[17:0];
                dry_now_reg   <= dry_sm[15:0];
                wet_now_reg   <= wet_sm[15:0];
            end
            if (push) phase_reg <= phase_reg + step_now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            xl_reg <= s_data.left_in;
            xr_reg <= s_data.right_in;
        end
        if (state_reg == F_LFO_L) lfo_l_reg <= lfo_sum[15:0];
        if (state_reg == F_LFO_R) lfo_r_reg <= lfo_sum[15:0];
        if (state_reg == F_OFF_L) off_l_reg <= off_clamp;
        if (state_reg == F_OFF_R) off_r_reg <= off_clamp;
    end

endmodule

// File: src/scd_back.sv
module scd_back import scd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  q_stat_t q_stat,
    input  job_t    job,
    output logic    pop,
    output logic    clearing,
    output logic    m_valid,
    input  logic    m_ready,
    output out_t    m_data
);

    back_state_t state_reg, state_next;

    logic signed [15:0] mem_l [DELAY_DEPTH];
    logic signed [15:0] mem_r [DELAY_DEPTH];

    logic [ADDR_W-1:0]  clr_cnt_reg, wpos_reg, raddr_l_reg, raddr_r_reg;
    logic signed [15:0] rdata_l_reg, rdata_r_reg, y0_l_reg, y0_r_reg;
    logic signed [15:0] tap_l_reg, tap_r_reg;
    logic signed [17:0] pd_l_reg, pd_r_reg, pw_l_reg, pw_r_reg;
    job_t               job_reg;
    logic               m_valid_reg;
    out_t               m_data_reg;

    logic               wen, commit;
    logic [ADDR_W-1:0]  waddr;
    logic signed [15:0] wdata_l, wdata_r;
    logic signed [15:0] tap_l, tap_r;
    logic signed [18:0] sum_l, sum_r;
    logic signed [15:0] sat_l, sat_r;

    assign clearing = (state_reg == B_CLEAR);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    function automatic logic signed [15:0] interp(input logic signed [15:0] y0,
                                                  input logic signed [15:0] y1,
                                                  input logic [7:0] f);
        logic signed [16:0] d;
        logic signed [25:0] p;
        logic signed [16:0] t;
        d = 17'(y1) - 17'(y0);
        p = 26'(d) * $signed({18'd0, f});
        t = 17'(y0) + 17'(p >>> 8);
        return t[15:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767)       return 16'sh7fff;
        else if (v < -19'sd32768) return 16'sh8000;
        else                      return v[15:0];
    endfunction

    always_comb begin
        tap_l = interp(y0_l_reg, rdata_l_reg, job_reg.frac_l);
        tap_r = interp(y0_r_reg, rdata_r_reg, job_reg.frac_r);
        sum_l = 19'(pd_l_reg) + 19'(pw_l_reg);
        sum_r = 19'(pd_r_reg) + 19'(pw_r_reg);
        sat_l = sat16(sum_l);
        sat_r = sat16(sum_r);
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            B_CLEAR: if (clr_cnt_reg == ADDR_W'(DELAY_DEPTH - 1)) state_next = B_IDLE;
            B_IDLE: begin
                if (!q_stat.empty) begin
                    pop        = 1'b1;
                    state_next = B_RD1;
                end
            end
            B_RD1: state_next = B_Y0;
            B_Y0:  state_next = B_Y1;
            B_Y1:  state_next = B_MUL;
            B_MUL: state_next = B_OUT;
            B_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    commit     = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        wen     = clearing || commit;
        waddr   = clearing ? clr_cnt_reg : wpos_reg;
        wdata_l = clearing ? 16'sd0 : job_reg.x_l;
        wdata_r = clearing ? 16'sd0 : job_reg.x_r;
    end

    always_ff @(posedge aclk) begin
        if (wen) begin
            mem_l[waddr] <= wdata_l;
            mem_r[waddr] <= wdata_r;
        end
        rdata_l_reg <= mem_l[raddr_l_reg];
        rdata_r_reg <= mem_r[raddr_r_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= B_CLEAR;
        else          state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            wpos_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (clearing) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (commit)   wpos_reg    <= wpos_reg + 1'b1;
            if (commit)             m_valid_reg <= 1'b1;
            else if (m_ready)       m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg     <= job;
            raddr_l_reg <= wpos_reg - job.whole_l;
            raddr_r_reg <= wpos_reg - job.whole_r;
        end
        // second tap is one sample further back
        if (state_reg == B_RD1) begin
            raddr_l_reg <= raddr_l_reg - 1'b1;
            raddr_r_reg <= raddr_r_reg - 1'b1;
        end
        if (state_reg == B_Y0) begin
            y0_l_reg <= rdata_l_reg;
            y0_r_reg <= rdata_r_reg;
        end
        if (state_reg == B_Y1) begin
            tap_l_reg <= tap_l;
            tap_r_reg <= tap_r;
        end
        if (state_reg == B_MUL) begin
            pd_l_reg <= 18'((33'(job_reg.x_l) * $signed({17'd0, job_reg.dry})) >>> 15);
            pd_r_reg <= 18'((33'(job_reg.x_r) * $signed({17'd0, job_reg.dry})) >>> 15);
            pw_l_reg <= 18'((33'(tap_l_reg) * $signed({17'd0, job_reg.wet})) >>> 15);
            pw_r_reg <= 18'((33'(tap_r_reg) * $signed({17'd0, job_reg.wet})) >>> 15);
        end
        if (commit) begin
            m_data_reg.left_out  <= sat_l;
            m_data_reg.right_out <= sat_r;
        end
    end

endmodule

// File: src/stereo_chorus_delay.sv
// channel  dir  handshake            payload
// s_       in   s_valid / s_ready    s_data (in_t)
// m_       out  m_valid / m_ready    m_data (out_t)
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Front: two LFO and two offset steps on shared units, then a push that waits while
// the queue is full. Back: two delay memory reads on one read port, then multiply, mix.
// Front and back each take a new item only when done with the last one.
// After reset the delay memories are zeroed, all 4096 entries, no items taken.
// A 2-deep queue lets the front run ahead while the output register stalls.
module stereo_chorus_delay import scd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic    push, pop, clearing;
    job_t    push_data, pop_data;
    q_stat_t q_stat;

    assign cfg_ready = 1'b1;

    scd_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .cfg_valid, .cfg_index, .cfg_data,
        .hold(clearing), .q_stat, .push, .push_data
    );

    scd_fifo u_fifo (
        .aclk, .aresetn, .push, .push_data, .pop, .pop_data, .stat(q_stat)
    );

    scd_back u_back (
        .aclk, .aresetn, .q_stat, .job(pop_data), .pop, .clearing,
        .m_valid, .m_ready, .m_data
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full) else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty) else $error("queue underflow");

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !m_valid && q_stat.empty) else $error("activity during clear");

endmodule
